>>> rtl/core/lgge_pkg.sv
package lgge_pkg;

  // Grid geometry
  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

  // Field and register widths
  localparam int CMD_W     = 2;
  localparam int POS_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NBR_W     = 4;

  localparam logic [CFG_W-1:0] ROWS_IN_USE_RESET = 7'd64;
  localparam logic [CFG_W-1:0] COLS_IN_USE_RESET = 7'd64;

  // B3/S23 neighbour counts
  localparam logic [NBR_W-1:0] LIFE_SURVIVE_MIN = 4'd2;
  localparam logic [NBR_W-1:0] LIFE_BIRTH       = 4'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_ADVANCE = 2'd3
  } lgge_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_IN_USE = 1'b0,
    CFG_COLS_IN_USE = 1'b1
  } lgge_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_ADV_WAIT,
    ST_ADV_RUN,
    ST_DONE
  } lgge_state_t;

  typedef logic [MAX_COLS-1:0] lgge_row_t;

  typedef struct packed {
    lgge_cmd_t        cmd;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             cell_value;
  } lgge_in_t;

  typedef struct packed {
    logic cell_state;
    logic in_range;
  } lgge_out_t;

  // Which of the three rows around the update row lie inside the active area
  typedef struct packed {
    logic up_live;
    logic mid_live;
    logic down_live;
  } lgge_upd_ctrl_t;

endpackage

>>> rtl/core/lgge_row_cell.sv
module lgge_row_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lgge_pkg::lgge_row_t row_in,
  output lgge_pkg::lgge_row_t row_out
);
  import lgge_pkg::*;

  lgge_row_t row_r;

  // Take the neighbour's row on every clock; reset kills every cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_in;
    end
  end

  assign row_out = row_r;

endmodule

>>> rtl/core/lgge_row_update.sv
module lgge_row_update (
  input  lgge_pkg::lgge_row_t      up_row,
  input  lgge_pkg::lgge_row_t      mid_row,
  input  lgge_pkg::lgge_row_t      down_row,
  input  lgge_pkg::lgge_row_t      col_mask,
  input  lgge_pkg::lgge_upd_ctrl_t ctrl,
  output lgge_pkg::lgge_row_t      next_row
);
  import lgge_pkg::*;

  lgge_row_t              up_m;
  lgge_row_t              mid_m;
  lgge_row_t              dn_m;
  logic [MAX_COLS+1:0]    up_p;
  logic [MAX_COLS+1:0]    mid_p;
  logic [MAX_COLS+1:0]    dn_p;

  // Dead outside the active area, and dead beyond both grid edges
  assign up_m  = up_row   & col_mask & {MAX_COLS{ctrl.up_live}};
  assign mid_m = mid_row  & col_mask & {MAX_COLS{ctrl.mid_live}};
  assign dn_m  = down_row & col_mask & {MAX_COLS{ctrl.down_live}};
  assign up_p  = {1'b0, up_m, 1'b0};
  assign mid_p = {1'b0, mid_m, 1'b0};
  assign dn_p  = {1'b0, dn_m, 1'b0};

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    logic [NBR_W-1:0] nbr_cnt;
    logic             alive;

    assign nbr_cnt = NBR_W'(up_p[c]) + NBR_W'(up_p[c+1]) + NBR_W'(up_p[c+2])
                   + NBR_W'(mid_p[c]) + NBR_W'(mid_p[c+2])
                   + NBR_W'(dn_p[c]) + NBR_W'(dn_p[c+1]) + NBR_W'(dn_p[c+2]);
    assign alive = mid_m[c] ? (nbr_cnt == LIFE_SURVIVE_MIN || nbr_cnt == LIFE_BIRTH)
                            : (nbr_cnt == LIFE_BIRTH);
    // Hold stored bits of columns outside the area
    assign next_row[c] = col_mask[c] ? alive : mid_row[c];
  end

endmodule

>>> rtl/core/life_grid_generation_engine.sv
// Game of Life (B3/S23) grid engine. The grid is held as a ring of MAX_ROWS
// row cells that rotates by one row every clock, so each row passes the head
// cell in turn; all cells are cleared to dead by reset directly, with no
// clearing pass. A write, read or peek inside the active area completes when
// its row reaches the head; its result is then loaded into the output
// register. An access outside the area completes without waiting for its
// row. An advance waits for row 0 to reach the head, then rewrites one row
// per cycle until row MAX_ROWS-1 has been at the head, and then loads the
// output register. The ring rotation sets these waits; a stalled output
// also delays its result. One item is in work at a time; the next one is
// taken while a finished result still waits in the output register. Cells
// outside the active area keep their stored bits.
module life_grid_generation_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lgge_pkg::lgge_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lgge_pkg::lgge_out_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [lgge_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lgge_pkg::CFG_W-1:0]           cfg_data
);
  import lgge_pkg::*;

  localparam logic [ROW_W-1:0] HEAD_LAST = ROW_W'(MAX_ROWS - 1);

  // Configuration
  logic [CFG_W-1:0]     rows_cfg_r;
  logic [CFG_W-1:0]     cols_cfg_r;
  logic [ROW_CNT_W-1:0] rows_act;
  logic [COL_CNT_W-1:0] cols_act;
  lgge_row_t            col_mask;

  // Control
  lgge_state_t          state_r;
  lgge_state_t          state_nxt;
  logic [ROW_W-1:0]     head_r;
  logic [ROW_W-1:0]     head_nxt;
  lgge_in_t             req_r;
  lgge_out_t            res_r;
  lgge_out_t            res_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  lgge_out_t            out_data_r;
  logic                 out_load;
  logic                 in_xfer;
  logic                 in_ok;
  logic                 head_match;
  logic                 adv_step;

  // Datapath
  lgge_row_t            cell_q [MAX_ROWS];
  lgge_row_t            wb_row;
  lgge_row_t            wr_row;
  lgge_row_t            up_sel;
  lgge_row_t            next_row;
  lgge_row_t            prev_old_r;
  lgge_upd_ctrl_t       upd_ctrl;
  logic [COL_W-1:0]     col_idx;

  // Saturate the area registers to the grid size
  always_comb begin
    if (32'(rows_cfg_r) > MAX_ROWS) begin
      rows_act = ROW_CNT_W'(MAX_ROWS);
    end else begin
      rows_act = ROW_CNT_W'(rows_cfg_r);
    end
    if (32'(cols_cfg_r) > MAX_COLS) begin
      cols_act = COL_CNT_W'(MAX_COLS);
    end else begin
      cols_act = COL_CNT_W'(cols_cfg_r);
    end
  end

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign col_mask[c] = (32'(c) < 32'(cols_act));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= ROWS_IN_USE_RESET;
      cols_cfg_r <= COLS_IN_USE_RESET;
    end else if (cfg_we) begin
      unique case (lgge_cfg_idx_t'(cfg_index))
        CFG_ROWS_IN_USE: rows_cfg_r <= cfg_data;
        CFG_COLS_IN_USE: cols_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Row ring: cell k holds logical row (head + k) mod MAX_ROWS. The head
  // row leaves through the write-back path into the last cell.
  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_ring
    if (k == MAX_ROWS - 1) begin : g_tail
      lgge_row_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .row_in  (wb_row),
        .row_out (cell_q[k])
      );
    end else begin : g_body
      lgge_row_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .row_in  (cell_q[k+1]),
        .row_out (cell_q[k])
      );
    end
  end

  // During an advance the row above has already been rewritten; use the
  // copy of its old value that was registered while it sat in the head cell.
  assign up_sel = (state_r == ST_ADV_RUN) ? prev_old_r : cell_q[MAX_ROWS-1];

  assign upd_ctrl.up_live   = (head_r != '0);
  assign upd_ctrl.mid_live  = (32'(head_r) < 32'(rows_act));
  assign upd_ctrl.down_live = ((32'(head_r) + 32'd1) < 32'(rows_act));

  lgge_row_update u_update (
    .up_row   (up_sel),
    .mid_row  (cell_q[0]),
    .down_row (cell_q[1]),
    .col_mask (col_mask),
    .ctrl     (upd_ctrl),
    .next_row (next_row)
  );

  always_ff @(posedge clk) begin
    prev_old_r <= cell_q[0];
  end

  assign col_idx    = COL_W'(req_r.col);
  assign head_match = (32'(head_r) == 32'(req_r.row));
  assign adv_step   = ((state_r == ST_ADV_WAIT) && (head_r == '0)) || (state_r == ST_ADV_RUN);

  // Write-back into the tail cell: new generation, written cell, or unchanged
  always_comb begin
    wr_row          = cell_q[0];
    wr_row[col_idx] = req_r.cell_value;
    priority if (adv_step && upd_ctrl.mid_live) begin
      wb_row = next_row;
    end else if ((state_r == ST_SEEK) && head_match && (req_r.cmd == CMD_WRITE)) begin
      wb_row = wr_row;
    end else begin
      wb_row = cell_q[0];
    end
  end

  // Advance the ring pointer every cycle
  assign head_nxt = (head_r == HEAD_LAST) ? '0 : head_r + 1'b1;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign in_ok    = (32'(in_data.row) < 32'(rows_act)) && (32'(in_data.col) < 32'(cols_act));

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          priority if (in_data.cmd == CMD_ADVANCE) begin
            state_nxt = ST_ADV_WAIT;
          end else if (in_ok) begin
            state_nxt = ST_SEEK;
          end else begin
            res_nxt   = '{cell_state: 1'b0, in_range: 1'b0};
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SEEK: begin
        if (head_match) begin
          res_nxt.in_range = 1'b1;
          unique case (req_r.cmd)
            CMD_READ: res_nxt.cell_state = cell_q[0][col_idx];
            CMD_PEEK: res_nxt.cell_state = next_row[col_idx];
            default:  res_nxt.cell_state = 1'b0;
          endcase
          state_nxt = ST_DONE;
        end
      end
      ST_ADV_WAIT: begin
        if (head_r == '0) begin
          state_nxt = ST_ADV_RUN;
        end
      end
      ST_ADV_RUN: begin
        if (head_r == HEAD_LAST) begin
          res_nxt   = '{cell_state: 1'b0, in_range: 1'b1};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_xfer) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> verif/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lgge_pkg::*;

  // Generous ceiling: it covers the slowest legal item plus the longest send gap
  // and result stall, over about 625 items.
  localparam int unsigned CYCLE_LIMIT  = 600_000;
  localparam int          RANDOM_ITEMS = 600;
  localparam int          CALM_TAIL    = 100;   // last transfers run with no idling
  localparam int          SETTLE       = 2 * MAX_ROWS + 2;

  // ---------------------------------------------------------------------------
  // Life grid predictor and result store
  // ---------------------------------------------------------------------------
  class life_scoreboard;
    typedef struct {
      lgge_in_t  cause;
      lgge_out_t res;
    } outcome_t;

    bit          grid [MAX_ROWS][MAX_COLS];
    int          rows_reg = ROWS_IN_USE_RESET;
    int          cols_reg = COLS_IN_USE_RESET;
    outcome_t    outcome_q[$];
    int unsigned mismatches, checked, live_seen, outside;
    int unsigned by_cmd [4];

    function int active_rows();
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    endfunction

    function int active_cols();
      return (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
    endfunction

    function void set_register(lgge_cfg_idx_t idx, logic [CFG_W-1:0] v);
      if (idx == CFG_ROWS_IN_USE) rows_reg = v;
      else                        cols_reg = v;
    endfunction

    // Cells beyond the active area count as dead
    function bit alive(int r, int c);
      if (r < 0 || c < 0 || r >= active_rows() || c >= active_cols()) return 1'b0;
      return grid[r][c];
    endfunction

    function bit successor(int r, int c);
      int n;
      n = 0;
      for (int dr = -1; dr <= 1; dr++)
        for (int dc = -1; dc <= 1; dc++)
          if (dr != 0 || dc != 0) n += alive(r + dr, c + dc);
      if (alive(r, c)) return (n == LIFE_SURVIVE_MIN || n == LIFE_BIRTH);
      return n == LIFE_BIRTH;
    endfunction

    // Whole active area steps at once from the old generation
    function void advance_generation();
      bit fresh [MAX_ROWS][MAX_COLS];
      for (int r = 0; r < active_rows(); r++)
        for (int c = 0; c < active_cols(); c++)
          fresh[r][c] = successor(r, c);
      for (int r = 0; r < active_rows(); r++)
        for (int c = 0; c < active_cols(); c++)
          grid[r][c] = fresh[r][c];
    endfunction

    function void note_transfer(lgge_in_t item);
      outcome_t e;
      bit       in_area;
      e.cause = item;
      e.res   = '0;
      by_cmd[item.cmd]++;
      if (item.cmd == CMD_ADVANCE) begin
        advance_generation();
        e.res.in_range = 1'b1;
      end else begin
        in_area = (int'(item.row) < active_rows()) && (int'(item.col) < active_cols());
        e.res.in_range = in_area;
        if (!in_area) begin
          outside++;
        end else begin
          case (item.cmd)
            CMD_WRITE: grid[item.row][item.col] = item.cell_value;
            CMD_READ:  e.res.cell_state = grid[item.row][item.col];
            default:   e.res.cell_state = successor(item.row, item.col);
          endcase
        end
      end
      outcome_q.push_back(e);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(lgge_out_t got);
      outcome_t e;
      string    tag;
      if (outcome_q.size() == 0) begin
        report_mismatch($sformatf("result %b arrived with nothing outstanding", got));
        return;
      end
      e = outcome_q.pop_front();
      checked++;
      if (got.cell_state === 1'b1) live_seen++;
      tag = $sformatf("%s row %0d col %0d val %b", e.cause.cmd.name(), e.cause.row,
                      e.cause.col, e.cause.cell_value);
      if (got.cell_state !== e.res.cell_state)
        report_mismatch($sformatf("%s: cell_state %b, want %b", tag, got.cell_state,
                                  e.res.cell_state));
      if (got.in_range !== e.res.in_range)
        report_mismatch($sformatf("%s: in_range %b, want %b", tag, got.in_range,
                                  e.res.in_range));
    endtask

    function int pending();
      return outcome_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Signals and block under test
  // ---------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  lgge_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  lgge_out_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bit             idle_on;        // allow random gaps and stalls on both sides
  int             stall_left;
  int unsigned    cycles;
  int unsigned    area_settings;
  life_scoreboard sb = new();

  life_grid_generation_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: give up if the run hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[%0t] watchdog expired with %0d results outstanding", $realtime,
               sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Observe both channels at the edge; note the input first so the queue
  // always holds the oldest expectation at its head.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)   sb.note_transfer(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Result side back-pressure: stall bursts of random length while idling
  // is allowed, otherwise take every result at once.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left -= 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left  = $urandom_range(0, 14);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one transfer and hold it until taken. Valid is left high on exit
  // so back-to-back transfers never lower and raise it in one step.
  task send_transfer(lgge_in_t item);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task issue(lgge_cmd_t cmd, int r, int c, bit v);
    lgge_in_t item;
    item.cmd        = cmd;
    item.row        = POS_W'(r);
    item.col        = POS_W'(c);
    item.cell_value = v;
    send_transfer(item);
  endtask

  // Hold off the sender until every outstanding result is back. Let the clock
  // run on first so the final acceptance has been noted.
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Change the active area only once the engine is idle
  task write_area(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS_IN_USE;
    cfg_data  <= rows;
    sb.set_register(CFG_ROWS_IN_USE, rows);
    @(posedge clk);
    cfg_index <= CFG_COLS_IN_USE;
    cfg_data  <= cols;
    sb.set_register(CFG_COLS_IN_USE, cols);
    @(posedge clk);
    cfg_we    <= 1'b0;
    area_settings++;
  endtask

  // Favour small areas so patterns are dense; keep the extremes in the mix
  function automatic logic [CFG_W-1:0] pick_extent();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return CFG_W'($urandom_range(65, 127));
      4, 5, 6: return CFG_W'($urandom_range(3, 10));
      default: return CFG_W'($urandom_range(1, 64));
    endcase
  endfunction

  // Mostly commands aimed into an 8x8 window of the active area, the rest
  // fully random noise that also lands outside it.
  function automatic lgge_in_t make_item(int ar, int ac, int wr, int wc);
    lgge_in_t it;
    int       sel, r, c;
    sel           = $urandom_range(0, 99);
    it.cmd        = lgge_cmd_t'($urandom_range(0, 3));
    it.row        = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    it.col        = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    it.cell_value = ($urandom_range(0, 9) < 4);
    if (sel < 88 && ar > 0 && ac > 0) begin
      r = wr + $urandom_range(0, 7);
      if (r >= ar) r = $urandom_range(0, ar - 1);
      c = wc + $urandom_range(0, 7);
      if (c >= ac) c = $urandom_range(0, ac - 1);
      it.row = POS_W'(r);
      it.col = POS_W'(c);
      if (sel < 45)      it.cmd = CMD_WRITE;
      else if (sel < 65) it.cmd = CMD_PEEK;
      else if (sel < 80) it.cmd = CMD_READ;
      else               it.cmd = CMD_ADVANCE;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] rows_v, cols_v;
    int               sent, seg_len, ar, ac, wr, wc, phase;

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    out_stall  <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_ROWS_IN_USE;
    cfg_data   <= '0;
    stall_left  = 0;
    idle_on     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n      <= 1'b1;
    idle_on     = 1'b1;

    // Full 64x64 area from reset: far corners, then a blinker
    issue(CMD_WRITE,  0,  0, 1'b1);
    issue(CMD_WRITE, 63, 63, 1'b1);
    issue(CMD_READ,  63, 63, 1'b0);
    issue(CMD_PEEK,  63, 63, 1'b0);     // lone cell dies
    issue(CMD_WRITE, 20, 30, 1'b1);
    issue(CMD_WRITE, 20, 31, 1'b1);
    issue(CMD_WRITE, 20, 32, 1'b1);
    issue(CMD_PEEK,  19, 31, 1'b0);     // birth on three neighbours
    issue(CMD_PEEK,  20, 31, 1'b0);     // survival on two
    issue(CMD_PEEK,  20, 30, 1'b0);     // death on one
    issue(CMD_ADVANCE, 63, 63, 1'b1);   // position fields ignored
    issue(CMD_READ,  19, 31, 1'b0);
    issue(CMD_READ,  20, 30, 1'b0);
    issue(CMD_WRITE,  0,  0, 1'b0);

    // Empty area: every access out of range, advance a no-op
    write_area(7'd0, 7'd0);
    issue(CMD_WRITE,  0,  0, 1'b1);
    issue(CMD_READ,   0,  0, 1'b0);
    issue(CMD_ADVANCE, 0, 0, 1'b0);

    // Oversized registers saturate to the full grid
    write_area(7'd100, 7'd127);
    issue(CMD_READ,  63, 63, 1'b0);
    issue(CMD_PEEK,  20, 30, 1'b0);

    // Narrow strip; the rest of the grid keeps its bits untouched
    write_area(7'd3, 7'd1);
    issue(CMD_WRITE,  2,  0, 1'b1);
    issue(CMD_WRITE,  2,  1, 1'b1);     // just past the last column
    issue(CMD_READ,   3,  0, 1'b0);     // just past the last row
    issue(CMD_ADVANCE, 0, 0, 1'b0);

    // Grow back: stored bits outside the strip reappear
    write_area(7'd64, 7'd64);
    issue(CMD_READ,  63, 63, 1'b0);
    issue(CMD_READ,  20, 31, 1'b0);

    // Random phases, each under its own active area
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      rows_v = pick_extent();
      cols_v = pick_extent();
      write_area(rows_v, cols_v);
      ar = (rows_v > MAX_ROWS) ? MAX_ROWS : rows_v;
      ac = (cols_v > MAX_COLS) ? MAX_COLS : cols_v;
      wr = (ar > 8) ? $urandom_range(0, ar - 8) : 0;
      wc = (ac > 8) ? $urandom_range(0, ac - 8) : 0;
      // Idle in most phases, never in the closing stretch
      idle_on = (sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      seg_len = $urandom_range(20, 60);
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        send_transfer(make_item(ar, ac, wr, wc));
        sent++;
        // Let the engine run dry mid-phase now and then
        if (k == seg_len / 2 && (phase == 2 || $urandom_range(0, 3) == 0)) drain();
      end
      phase++;
    end

    drain();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d transfers: %0d writes, %0d reads, %0d peeks, %0d advances, %0d outside.",
             sb.by_cmd[CMD_WRITE] + sb.by_cmd[CMD_READ] + sb.by_cmd[CMD_PEEK] +
             sb.by_cmd[CMD_ADVANCE], sb.by_cmd[CMD_WRITE], sb.by_cmd[CMD_READ],
             sb.by_cmd[CMD_PEEK], sb.by_cmd[CMD_ADVANCE], sb.outside);
    $display("Checked %0d results (%0d live) across %0d active-area settings.",
             sb.checked, sb.live_seen, area_settings);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/core/lgge_pkg.sv
rtl/core/lgge_row_cell.sv
rtl/core/lgge_row_update.sv
rtl/core/life_grid_generation_engine.sv
verif/testbench.sv
